### hw/rtl/mwo_pkg.sv
// Shared constants, types and the quarter-wave sine table of the oscillator.
// Used by every module of the oscillator and by its checker; depends on nothing.
package mwo_pkg;

  localparam int unsigned IDX_W            = 32;
  localparam int unsigned FREQ_W           = 24;
  localparam int unsigned SR_W             = 18;
  localparam int unsigned OFS_W            = 14;
  localparam int unsigned WAV_W            = 2;
  localparam int unsigned PADDR_W          = 4;
  localparam int unsigned PDATA_W          = 32;

  localparam int unsigned PHASE_BITS       = 16;
  localparam int unsigned SAMPLE_BITS      = 16;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;

  localparam int unsigned FREQ_SCALE       = 100;
  localparam int unsigned OFS_MOD          = 10000;

  // Divisor 100*sample_rate and cycle modulus 10000*divisor.
  localparam int unsigned D_W = 25;
  localparam int unsigned M_W = 38;
  localparam int unsigned N_W = M_W + 1;

  // Product remainder: bits retired per stage and number of stages.
  localparam int unsigned MOD_BPS    = 2;
  localparam int unsigned PROD_W     = IDX_W + FREQ_W;
  localparam int unsigned MOD_STAGES = (PROD_W + MOD_BPS - 1) / MOD_BPS;
  localparam int unsigned MP_W       = MOD_STAGES * MOD_BPS;

  // Phase quotient: bits produced per stage and number of stages.
  localparam int unsigned DIV_BPS    = 2;
  localparam int unsigned DIV_STAGES = (PHASE_BITS + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned Q_W        = DIV_STAGES * DIV_BPS;

  localparam int unsigned ROM_AW     = $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic [1:0] REG_SAMPLE_RATE  = 2'd0;
  localparam logic [1:0] REG_PHASE_OFFSET = 2'd1;
  localparam logic [1:0] REG_WAVEFORM     = 2'd2;

  typedef enum logic [WAV_W-1:0] {
    WAVE_SINE = 2'd0,
    WAVE_SAW  = 2'd1,
    WAVE_TRI  = 2'd2
  } wave_e;

  typedef struct packed {
    logic [SR_W-1:0]  sample_rate;
    logic [OFS_W-1:0] phase_offset;
    logic [WAV_W-1:0] waveform;
  } cfg_t;

  typedef logic [SAMPLE_BITS-2:0] rom_word_t;
  typedef rom_word_t rom_t [SINE_TABLE_DEPTH+1];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  // Taylor series of sin in Q30 fixed point, evaluated at elaboration.
  // Term n is divided by (2n)(2n+1); the signs alternate starting with minus.
  function automatic longint unsigned sin_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    return sum;
  endfunction

  function automatic rom_t build_sine_rom();
    rom_t            rom;
    longint unsigned fsmax;
    longint unsigned ang;
    longint unsigned s;
    longint unsigned v;
    fsmax = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k <= int'(SINE_TABLE_DEPTH); k++) begin
      ang = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      s   = sin_q30(ang);
      if (s > ONE_Q30) begin
        s = ONE_Q30;
      end
      v = (s * fsmax + (64'd1 << 29)) >> 30;
      if (v > fsmax) begin
        v = fsmax;
      end
      rom[k] = rom_word_t'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

endpackage

### hw/rtl/mwo_phase.sv
// Phase pipeline: product, remainder by 100*sample_rate, offset and phase quotient.
// Depends on mwo_pkg.
module mwo_phase (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [mwo_pkg::IDX_W-1:0]          sample_index_i,
  input  logic [mwo_pkg::FREQ_W-1:0]         frequency_i,
  input  mwo_pkg::cfg_t                      cfg_i,
  output logic                               valid_o,
  output logic [mwo_pkg::PHASE_BITS-1:0]     phase_o
);

  logic [mwo_pkg::D_W-1:0]   div_d;
  logic [mwo_pkg::M_W-1:0]   mod_m;
  logic [mwo_pkg::OFS_W-1:0] ofs_red;

  // A zero sample rate makes the divisor one, so the index term drops out.
  assign div_d = (cfg_i.sample_rate == '0) ? mwo_pkg::D_W'(1) :
                 mwo_pkg::D_W'(mwo_pkg::D_W'(cfg_i.sample_rate) *
                               mwo_pkg::D_W'(mwo_pkg::FREQ_SCALE));
  assign mod_m = mwo_pkg::M_W'(mwo_pkg::M_W'(div_d) * mwo_pkg::M_W'(mwo_pkg::OFS_MOD));
  assign ofs_red = (cfg_i.phase_offset >= mwo_pkg::OFS_W'(mwo_pkg::OFS_MOD)) ?
                   cfg_i.phase_offset - mwo_pkg::OFS_W'(mwo_pkg::OFS_MOD) :
                   cfg_i.phase_offset;

  logic                      prod_vld_q;
  logic [mwo_pkg::MP_W-1:0]  prod_q;

  logic                      mvld_q [mwo_pkg::MOD_STAGES];
  logic [mwo_pkg::MP_W-1:0]  mbits_q [mwo_pkg::MOD_STAGES];
  logic [mwo_pkg::MP_W-1:0]  mbits_d [mwo_pkg::MOD_STAGES];
  logic [mwo_pkg::D_W-1:0]   mrem_q [mwo_pkg::MOD_STAGES];
  logic [mwo_pkg::D_W-1:0]   mrem_d [mwo_pkg::MOD_STAGES];

  logic                      nraw_vld_q;
  logic [mwo_pkg::N_W-1:0]   nraw_q;
  logic                      n_vld_q;
  logic [mwo_pkg::M_W-1:0]   n_q;

  logic                      dvld_q [mwo_pkg::DIV_STAGES];
  logic [mwo_pkg::M_W-1:0]   dnum_q [mwo_pkg::DIV_STAGES];
  logic [mwo_pkg::M_W-1:0]   dnum_d [mwo_pkg::DIV_STAGES];
  logic [mwo_pkg::Q_W-1:0]   dquo_q [mwo_pkg::DIV_STAGES];
  logic [mwo_pkg::Q_W-1:0]   dquo_d [mwo_pkg::DIV_STAGES];

  // Restoring remainder of the product, a few bits per stage, MSB first.
  always_comb begin
    logic [mwo_pkg::MP_W-1:0] bits;
    logic [mwo_pkg::D_W-1:0]  rem;
    logic [mwo_pkg::D_W:0]    t;
    for (int s = 0; s < int'(mwo_pkg::MOD_STAGES); s++) begin
      bits = (s == 0) ? prod_q : mbits_q[(s == 0) ? 0 : s - 1];
      rem  = (s == 0) ? '0 : mrem_q[(s == 0) ? 0 : s - 1];
      for (int b = 0; b < int'(mwo_pkg::MOD_BPS); b++) begin
        t    = {rem, bits[mwo_pkg::MP_W-1]};
        bits = bits << 1;
        if (t >= {1'b0, div_d}) begin
          t = t - {1'b0, div_d};
        end
        rem = t[mwo_pkg::D_W-1:0];
      end
      mbits_d[s] = bits;
      mrem_d[s]  = rem;
    end
  end

  // Restoring division n*2^Q/m, a few quotient bits per stage.
  always_comb begin
    logic [mwo_pkg::M_W-1:0] num;
    logic [mwo_pkg::Q_W-1:0] quo;
    logic [mwo_pkg::N_W-1:0] t;
    for (int s = 0; s < int'(mwo_pkg::DIV_STAGES); s++) begin
      num = (s == 0) ? n_q : dnum_q[(s == 0) ? 0 : s - 1];
      quo = (s == 0) ? '0 : dquo_q[(s == 0) ? 0 : s - 1];
      for (int b = 0; b < int'(mwo_pkg::DIV_BPS); b++) begin
        t = {num, 1'b0};
        if (t >= {1'b0, mod_m}) begin
          t   = t - {1'b0, mod_m};
          quo = {quo[mwo_pkg::Q_W-2:0], 1'b1};
        end else begin
          quo = {quo[mwo_pkg::Q_W-2:0], 1'b0};
        end
        num = t[mwo_pkg::M_W-1:0];
      end
      dnum_d[s] = num;
      dquo_d[s] = quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      nraw_vld_q <= 1'b0;
      n_vld_q    <= 1'b0;
      for (int s = 0; s < int'(mwo_pkg::MOD_STAGES); s++) begin
        mvld_q[s] <= 1'b0;
      end
      for (int s = 0; s < int'(mwo_pkg::DIV_STAGES); s++) begin
        dvld_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      prod_vld_q <= valid_i;
      mvld_q[0]  <= prod_vld_q;
      for (int s = 1; s < int'(mwo_pkg::MOD_STAGES); s++) begin
        mvld_q[s] <= mvld_q[s-1];
      end
      nraw_vld_q <= mvld_q[mwo_pkg::MOD_STAGES-1];
      n_vld_q    <= nraw_vld_q;
      dvld_q[0]  <= n_vld_q;
      for (int s = 1; s < int'(mwo_pkg::DIV_STAGES); s++) begin
        dvld_q[s] <= dvld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= mwo_pkg::MP_W'(mwo_pkg::MP_W'(sample_index_i) * mwo_pkg::MP_W'(frequency_i));
      for (int s = 0; s < int'(mwo_pkg::MOD_STAGES); s++) begin
        mbits_q[s] <= mbits_d[s];
        mrem_q[s]  <= mrem_d[s];
      end
      // Both terms stay below m, so one conditional subtract wraps the sum.
      nraw_q <= mwo_pkg::N_W'(mwo_pkg::N_W'(mrem_q[mwo_pkg::MOD_STAGES-1]) *
                              mwo_pkg::N_W'(mwo_pkg::OFS_MOD)) +
                mwo_pkg::N_W'(mwo_pkg::N_W'(ofs_red) * mwo_pkg::N_W'(div_d));
      n_q <= (nraw_q >= {1'b0, mod_m}) ? mwo_pkg::M_W'(nraw_q - {1'b0, mod_m}) :
                                         nraw_q[mwo_pkg::M_W-1:0];
      for (int s = 0; s < int'(mwo_pkg::DIV_STAGES); s++) begin
        dnum_q[s] <= dnum_d[s];
        dquo_q[s] <= dquo_d[s];
      end
    end
  end

  assign valid_o = dvld_q[mwo_pkg::DIV_STAGES-1];
  assign phase_o = dquo_q[mwo_pkg::DIV_STAGES-1][mwo_pkg::Q_W-1 -: mwo_pkg::PHASE_BITS];

endmodule

### hw/rtl/mwo_shape.sv
// Waveform stage: maps a phase word to a sine, saw or triangle sample, or zero for select 3.
// Depends on mwo_pkg; the last register here is the block's output register.
module mwo_shape (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [mwo_pkg::PHASE_BITS-1:0]      phase_i,
  input  mwo_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  output logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned PB = mwo_pkg::PHASE_BITS;
  localparam int unsigned SB = mwo_pkg::SAMPLE_BITS;
  localparam int unsigned IW = PB + mwo_pkg::ROM_AW + 1;

  logic [1:0]                  quad;
  logic [PB-2:0]               qq;
  logic [IW-1:0]               idx_full;
  logic [mwo_pkg::ROM_AW-1:0]  idx_d;
  logic [SB-1:0]               saw_d;
  logic [SB:0]                 tri_u;
  logic [SB+1:0]               tri_t;
  logic [SB-1:0]               tri_d;

  assign quad = phase_i[PB-1 -: 2];
  // Falling quadrants read the table mirrored about the quarter point.
  assign qq = quad[0] ? (PB-1)'((PB-1)'(1) << (PB - 2)) - (PB-1)'(phase_i[PB-3:0]) :
                        (PB-1)'(phase_i[PB-3:0]);
  assign idx_full = (IW'(IW'(qq) * IW'(mwo_pkg::SINE_TABLE_DEPTH)) +
                     (IW'(1) << (PB - 3))) >> (PB - 2);
  assign idx_d = (idx_full > IW'(mwo_pkg::SINE_TABLE_DEPTH)) ?
                 mwo_pkg::ROM_AW'(mwo_pkg::SINE_TABLE_DEPTH) :
                 idx_full[mwo_pkg::ROM_AW-1:0];

  // Subtracting half scale from an unsigned value below full scale flips the MSB.
  assign saw_d = SB'(((PB+SB)'(phase_i) << SB) >> PB) ^ (SB'(1) << (SB - 1));

  assign tri_u = (SB+1)'(((PB+SB+1)'(phase_i) << (SB + 1)) >> PB);
  assign tri_t = (SB+2)'(3 * (2 ** (SB - 1))) - (SB+2)'(tri_u);
  always_comb begin
    if (!tri_u[SB]) begin
      tri_d = tri_u[SB-1:0] ^ (SB'(1) << (SB - 1));
    end else if (tri_u == ((SB+1)'(1) << SB)) begin
      tri_d = ~(SB'(1) << (SB - 1));
    end else begin
      tri_d = tri_t[SB-1:0];
    end
  end

  logic                        a_vld_q;
  logic [mwo_pkg::ROM_AW-1:0]  a_idx_q;
  logic                        a_neg_q;
  logic [SB-1:0]               a_saw_q;
  logic [SB-1:0]               a_tri_q;
  logic                        out_vld_q;
  logic [SB-1:0]               out_q;
  logic [SB-1:0]               sine_mag;
  logic [SB-1:0]               out_d;

  assign sine_mag = SB'(mwo_pkg::SINE_ROM[a_idx_q]);

  always_comb begin
    case (cfg_i.waveform)
      mwo_pkg::WAVE_SINE: out_d = a_neg_q ? -sine_mag : sine_mag;
      mwo_pkg::WAVE_SAW:  out_d = a_saw_q;
      mwo_pkg::WAVE_TRI:  out_d = a_tri_q;
      default:            out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q   <= valid_i;
      out_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_idx_q <= idx_d;
      a_neg_q <= quad[1];
      a_saw_q <= saw_d;
      a_tri_q <= tri_d;
      out_q   <= out_d;
    end
  end

  assign valid_o  = out_vld_q;
  assign sample_o = out_q;

endmodule

### hw/rtl/multi_waveform_oscillator.sv
// Top level of the multi-waveform oscillator: register port, handshake and pipeline.
// Depends on mwo_pkg, mwo_phase and mwo_shape.

// The oscillator takes one transaction per clock while the output is not stalled:
// a sample index and a frequency in hundredths of a hertz. For each it returns one
// signed Q1.15 sample of the selected waveform (sine from a quarter-wave table, saw,
// or triangle) at phase frac(index*frequency/(100*sample_rate) + phase_offset/10000),
// truncated to a 16-bit phase word. A new transaction is accepted every cycle unless
// an untaken result waits at the output; each result passes through 41 register
// stages, of which the first loads at the accepting edge. These are the restoring
// remainder of the 56-bit product (28 stages, two bits each) and the restoring phase
// division (8 stages, two bits each), plus the multiply, offset and waveform stages.
// The whole pipeline freezes while a finished result waits at the output, so nothing
// is lost or repeated. Registers sample_rate (address 0), phase_offset (4) and
// waveform (8) may only be written while no transaction is in flight.
module multi_waveform_oscillator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [mwo_pkg::IDX_W-1:0]              sample_index_i,
  input  logic [mwo_pkg::FREQ_W-1:0]             frequency_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample_value_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mwo_pkg::PADDR_W-1:0]            paddr,
  input  logic [mwo_pkg::PDATA_W-1:0]            pwdata,
  output logic [mwo_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);

  mwo_pkg::cfg_t cfg_q;
  logic          adv;
  logic          ph_vld;
  logic [mwo_pkg::PHASE_BITS-1:0] ph;

  // Every stage moves together; it stops only when the output holds a result
  // that the consumer has not taken.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign pready     = 1'b1;

  // Register writes complete in the access cycle of the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate  <= mwo_pkg::SR_W'(48000);
      cfg_q.phase_offset <= '0;
      cfg_q.waveform     <= mwo_pkg::WAVE_SINE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        mwo_pkg::REG_SAMPLE_RATE:  cfg_q.sample_rate  <= pwdata[mwo_pkg::SR_W-1:0];
        mwo_pkg::REG_PHASE_OFFSET: cfg_q.phase_offset <= pwdata[mwo_pkg::OFS_W-1:0];
        mwo_pkg::REG_WAVEFORM:     cfg_q.waveform     <= pwdata[mwo_pkg::WAV_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the register value, zero-extended; unmapped addresses read zero.
  always_comb begin
    unique case (paddr[3:2])
      mwo_pkg::REG_SAMPLE_RATE:  prdata = mwo_pkg::PDATA_W'(cfg_q.sample_rate);
      mwo_pkg::REG_PHASE_OFFSET: prdata = mwo_pkg::PDATA_W'(cfg_q.phase_offset);
      mwo_pkg::REG_WAVEFORM:     prdata = mwo_pkg::PDATA_W'(cfg_q.waveform);
      default:                   prdata = '0;
    endcase
  end

  mwo_phase u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .valid_i        (in_valid_i),
    .sample_index_i (sample_index_i),
    .frequency_i    (frequency_i),
    .cfg_i          (cfg_q),
    .valid_o        (ph_vld),
    .phase_o        (ph)
  );

  mwo_shape u_shape (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (ph_vld),
    .phase_i  (ph),
    .cfg_i    (cfg_q),
    .valid_o  (out_valid_o),
    .sample_o (sample_value_o)
  );

endmodule

### hw/rtl/mwo_checker.sv
// Port-level checks for the multi-waveform oscillator, bound to its top level.
// Depends on mwo_pkg and multi_waveform_oscillator.
module mwo_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample_value_o,
  input logic                                   psel,
  input logic                                   pwrite,
  input logic [mwo_pkg::PADDR_W-1:0]            paddr,
  input logic [mwo_pkg::PDATA_W-1:0]            prdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sample_value_o))
    else $error("result changed while stalled");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stall");

  a_wave_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && (paddr[3:2] == mwo_pkg::REG_WAVEFORM) |->
      (prdata[mwo_pkg::PDATA_W-1:mwo_pkg::WAV_W] == '0))
    else $error("waveform register read wider than its field");

endmodule

bind multi_waveform_oscillator mwo_checker u_mwo_checker (.*);

### sim/tb.sv
// Self-checking testbench for multi_waveform_oscillator: random and directed
// transactions checked against an in-bench predictor. Depends on mwo_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Holds expected samples in order and counts mismatches.
  class sample_board;
    logic signed [mwo_pkg::SAMPLE_BITS-1:0] pending[$];
    int errors = 0;

    function void note_input(logic signed [mwo_pkg::SAMPLE_BITS-1:0] v);
      pending = {pending, v};
    endfunction

    function void check_sample(logic signed [mwo_pkg::SAMPLE_BITS-1:0] got);
      logic signed [mwo_pkg::SAMPLE_BITS-1:0] want;
      if (pending.size() == 0) begin
        $error("sample_value: unexpected result %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $error("sample_value: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [mwo_pkg::IDX_W-1:0] sample_index_i = '0;
  logic [mwo_pkg::FREQ_W-1:0] frequency_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample_value_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [mwo_pkg::PADDR_W-1:0] paddr = '0;
  logic [mwo_pkg::PDATA_W-1:0] pwdata = '0;
  logic [mwo_pkg::PDATA_W-1:0] prdata;
  logic pready;

  multi_waveform_oscillator i_dut (.*);

  always #5 clk_i = ~clk_i;

  // The predictor keeps its own copy of the register settings.
  logic [mwo_pkg::SR_W-1:0]  rate_q = 18'd48000;
  logic [mwo_pkg::OFS_W-1:0] offset_q = '0;
  logic [mwo_pkg::WAV_W-1:0] shape_q = mwo_pkg::WAVE_SINE;
  mwo_pkg::rom_word_t        quarter_sine [mwo_pkg::SINE_TABLE_DEPTH+1];

  sample_board board = new();
  bit quiet = 1'b0;       // When set, neither side idles.
  bit hold_sink = 1'b0;   // Long receiver stall requested.
  int sink_idle = 0;      // Remaining cycles of a receiver idle burst.

  // Q30 Taylor series for the quarter-wave table, evaluated once at start.
  function automatic longint unsigned taylor_sin(longint unsigned x);
    longint unsigned x2, term, acc;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic longint unsigned table_at(longint unsigned q);
    longint unsigned k;
    k = (q * mwo_pkg::SINE_TABLE_DEPTH + (64'd1 << (mwo_pkg::PHASE_BITS - 3))) >>
        (mwo_pkg::PHASE_BITS - 2);
    if (k > mwo_pkg::SINE_TABLE_DEPTH) k = mwo_pkg::SINE_TABLE_DEPTH;
    return quarter_sine[k];
  endfunction

  // Exact rational phase, then the selected waveform.
  function automatic logic signed [mwo_pkg::SAMPLE_BITS-1:0] predict_sample(
      logic [mwo_pkg::IDX_W-1:0] idx, logic [mwo_pkg::FREQ_W-1:0] freq);
    longint unsigned div, rem, modulus, num, ph, quad, q;
    longint half, v, u;
    half = longint'(1) << (mwo_pkg::SAMPLE_BITS - 1);
    div = 100 * longint'(rate_q);
    rem = 0;
    if (div == 0) div = 1;
    else rem = (longint'(idx) * longint'(freq)) % div;
    modulus = 10000 * div;
    num = (rem * 10000 + longint'(offset_q) * div) % modulus;
    ph = (num << mwo_pkg::PHASE_BITS) / modulus;
    case (shape_q)
      mwo_pkg::WAVE_SINE: begin
        quad = ph >> (mwo_pkg::PHASE_BITS - 2);
        q = ph & ((64'd1 << (mwo_pkg::PHASE_BITS - 2)) - 1);
        v = (quad & 1) ? longint'(table_at((64'd1 << (mwo_pkg::PHASE_BITS - 2)) - q)) :
                         longint'(table_at(q));
        if (quad & 2) v = -v;
      end
      mwo_pkg::WAVE_SAW:
        v = longint'((ph << mwo_pkg::SAMPLE_BITS) >> mwo_pkg::PHASE_BITS) - half;
      mwo_pkg::WAVE_TRI: begin
        u = longint'((ph << (mwo_pkg::SAMPLE_BITS + 1)) >> mwo_pkg::PHASE_BITS);
        v = (u < 2 * half) ? u - half : 3 * half - u;
        if (v > half - 1) v = half - 1;
        if (v < -half) v = -half;
      end
      default: v = 0;
    endcase
    return v[mwo_pkg::SAMPLE_BITS-1:0];
  endfunction

  // APB write: setup then access cycle; the model copy follows the write.
  task automatic write_reg(logic [1:0] reg_id, logic [mwo_pkg::PDATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= mwo_pkg::PADDR_W'(reg_id) << 2; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (reg_id)
      mwo_pkg::REG_SAMPLE_RATE:  rate_q = value[mwo_pkg::SR_W-1:0];
      mwo_pkg::REG_PHASE_OFFSET: offset_q = value[mwo_pkg::OFS_W-1:0];
      default:                   shape_q = value[mwo_pkg::WAV_W-1:0];
    endcase
  endtask

  // Withdraw the input valid at the edge of the last accepted transaction.
  task automatic stop_input();
    in_valid_i <= 1'b0;
  endtask

  // Offer one transaction; random idle bursts precede it unless quiet is set.
  // Valid stays high across back-to-back transactions.
  task automatic send_item(logic [mwo_pkg::IDX_W-1:0] idx,
                           logic [mwo_pkg::FREQ_W-1:0] freq);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_index_i <= idx;
    frequency_i <= freq;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(predict_sample(idx, freq));
  endtask

  // Block is idle once nothing is expected; then allow the pipeline to settle.
  task automatic drain();
    stop_input();
    wait (board.pending.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [mwo_pkg::FREQ_W-1:0] rand_freq();
    case ($urandom_range(0, 3))
      0: return mwo_pkg::FREQ_W'($urandom);
      1: return mwo_pkg::FREQ_W'($urandom_range(0, 9600000));
      2: return mwo_pkg::FREQ_W'($urandom_range(0, 200000));
      default: return mwo_pkg::FREQ_W'($urandom_range(0, 100));
    endcase
  endfunction

  // Receiver: random idle bursts, or a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_sink) out_ready_i <= 1'b0;
    else if (quiet) out_ready_i <= 1'b1;
    else if (sink_idle > 0) begin
      out_ready_i <= 1'b0;
      sink_idle <= sink_idle - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      sink_idle <= $urandom_range(0, 6);
    end else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_sample(sample_value_o);
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    logic [mwo_pkg::SR_W-1:0] rates[4] = '{18'd8000, 18'd192000, 18'd48000, 18'd0};
    logic [mwo_pkg::OFS_W-1:0] ofs[4] = '{14'd0, 14'd10000, 14'd2500, 14'h3FFF};
    for (int k = 0; k <= mwo_pkg::SINE_TABLE_DEPTH; k++) begin
      longint unsigned s, v;
      s = taylor_sin((longint'(k) * 64'd1686629713) / mwo_pkg::SINE_TABLE_DEPTH);
      if (s > 64'd1073741824) s = 64'd1073741824;
      v = (s * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      quarter_sine[k] = mwo_pkg::rom_word_t'(v);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes across all shapes, including select 3.
    for (int w = 0; w < 4; w++) begin
      write_reg(mwo_pkg::REG_WAVEFORM, mwo_pkg::PDATA_W'(w));
      send_item('0, '0);
      send_item('1, '1);
      send_item(32'd12000, 24'd9600000);
      send_item(32'd1, 24'd2400000);
      send_item(32'd3, 24'd2400000);
      drain();
    end
    write_reg(mwo_pkg::REG_SAMPLE_RATE, '0);
    write_reg(mwo_pkg::REG_PHASE_OFFSET, mwo_pkg::PDATA_W'(10000));
    write_reg(mwo_pkg::REG_WAVEFORM, mwo_pkg::PDATA_W'(mwo_pkg::WAVE_TRI));
    send_item(32'd77, 24'd440);
    send_item('1, 24'hFFFFFF);
    drain();

    // Random phases, each with a fresh setting; the last phase runs quiet.
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 13) quiet = 1'b1;
      write_reg(mwo_pkg::REG_SAMPLE_RATE, (ph < 4) ? mwo_pkg::PDATA_W'(rates[ph]) :
                mwo_pkg::PDATA_W'($urandom_range(8000, 192000)));
      write_reg(mwo_pkg::REG_PHASE_OFFSET, (ph < 4) ? mwo_pkg::PDATA_W'(ofs[ph]) :
                mwo_pkg::PDATA_W'($urandom_range(0, 10000)));
      write_reg(mwo_pkg::REG_WAVEFORM, (ph == 3) ? mwo_pkg::PDATA_W'(3) :
                mwo_pkg::PDATA_W'(ph % 3));
      if (ph == 5) begin
        fork
          begin
            hold_sink = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_sink = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 125; n++) begin
        send_item($urandom(), rand_freq());
        if (ph == 8 && n == 60) begin
          stop_input();
          wait (board.pending.size() == 0);
        end
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
